// ===== rtl/rlt_pkg.sv =====
// ----------------------------------------------------------------------------
// rlt_pkg: route lock table shared definitions
// Field types, action and status codes, route row layout and FSM states.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int ROUTES     = 64;
    localparam int SLOTS      = 4;
    localparam int COUNT_BITS = 8;

    localparam int ACTION_W = 3;
    localparam int ROUTE_W  = 6;
    localparam int REQ_W    = 8;
    localparam int STATUS_W = 3;
    localparam int SLOT_IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [ACTION_W-1:0] ACT_PUSH          = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP           = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_TRY_BLOCK     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_UNLOCK        = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_AND_BLOCK = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_HARD_BLOCK    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_HARD_UNLOCK   = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_DONE        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RETRY       = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_BLOCKED = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_UNIQUE  = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW    = 3'd6;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ROUTE_W-1:0]  route;
        logic [REQ_W-1:0]    requester;
    } req_t;

    typedef struct packed {
        logic                granted;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic                              blocked;
        logic [SLOTS-1:0][REQ_W-1:0]       owner;
        logic [SLOTS-1:0][COUNT_BITS-1:0]  count;
    } row_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_OUT
    } state_t;

endpackage

// ===== rtl/rlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// rlt_ctrl: route lock table controller
// Sequences capture, row read-modify-write and result handoff.
// ----------------------------------------------------------------------------
module rlt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output rlt_pkg::cmd_t cmd
);

    rlt_pkg::state_t state_reg;
    rlt_pkg::state_t state_next;
    logic            accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rlt_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rlt_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    state_next = rlt_pkg::FSM_EXEC;
                end
            end
            rlt_pkg::FSM_EXEC: begin
                state_next = rlt_pkg::FSM_OUT;
            end
            rlt_pkg::FSM_OUT: begin
                if (m_ready) begin
                    state_next = s_valid ? rlt_pkg::FSM_EXEC : rlt_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = rlt_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            rlt_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
            end
            rlt_pkg::FSM_EXEC: begin
                cmd.exec = 1'b1;
            end
            rlt_pkg::FSM_OUT: begin
                m_valid = 1'b1;
                s_ready = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.capture = accept;
    end

    // a new transaction overlaps a pending result only as that result leaves
    a_ready_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_ready && m_valid) |-> m_ready)
        else $error("input taken while result stalled");

    // every executed row update produces a result next cycle
    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("executed transaction has no result");

    // capture is always followed by execution
    a_capture_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.exec)
        else $error("captured transaction not executed");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && cmd.capture))
        else $error("capture during row update");

endmodule

// ===== rtl/rlt_dp.sv =====
// ----------------------------------------------------------------------------
// rlt_dp: route lock table datapath
// Route row memory with per-row valid bits, slot logic and result register.
// ----------------------------------------------------------------------------
module rlt_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  rlt_pkg::cmd_t    cmd,
    input  rlt_pkg::req_t    s_data,
    output rlt_pkg::result_t m_data
);

    localparam int DEPTH = 2 ** rlt_pkg::ROUTE_W;

    rlt_pkg::row_t             mem [DEPTH];
    logic [DEPTH-1:0]          row_valid_reg;
    rlt_pkg::row_t             rd_row_reg;
    logic                      rd_valid_reg;
    rlt_pkg::req_t             in_reg;
    rlt_pkg::result_t          out_reg;

    rlt_pkg::row_t             row;
    rlt_pkg::row_t             add_row;
    rlt_pkg::row_t             rem_row;
    rlt_pkg::row_t             row_next;
    logic [rlt_pkg::STATUS_W-1:0] add_st;
    logic [rlt_pkg::STATUS_W-1:0] rem_st;
    logic [rlt_pkg::STATUS_W-1:0] status;
    logic                      granted;
    logic                      write_en;
    logic                      in_range;
    logic [rlt_pkg::SLOTS-1:0] match;
    logic [rlt_pkg::SLOTS-1:0] zero;
    logic                      own_hit;
    logic                      free_hit;
    logic [rlt_pkg::SLOT_IW-1:0] own_idx;
    logic [rlt_pkg::SLOT_IW-1:0] free_idx;
    logic                      blockable;
    logic                      unique_req;
    logic                      last_ref;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_row_reg <= mem[s_data.route];
            in_reg     <= s_data;
        end
        if (write_en) begin
            mem[in_reg.route] <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (cmd.capture) begin
                rd_valid_reg <= row_valid_reg[s_data.route];
            end
            if (write_en) begin
                row_valid_reg[in_reg.route] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_reg.granted <= granted;
            out_reg.status  <= status;
        end
    end

    assign m_data   = out_reg;
    assign row      = rd_valid_reg ? rd_row_reg : '0;
    assign in_range = {1'b0, in_reg.route} < (rlt_pkg::ROUTE_W + 1)'(rlt_pkg::ROUTES);
    assign write_en = cmd.exec && in_range;

    always_comb begin
        own_hit    = 1'b0;
        free_hit   = 1'b0;
        own_idx    = '0;
        free_idx   = '0;
        blockable  = 1'b1;
        unique_req = 1'b1;
        for (int i = rlt_pkg::SLOTS - 1; i >= 0; i--) begin
            match[i] = (row.owner[i] == in_reg.requester);
            zero[i]  = (row.count[i] == '0);
            if (match[i]) begin
                own_hit = 1'b1;
                own_idx = rlt_pkg::SLOT_IW'(i);
            end
            if (zero[i]) begin
                free_hit = 1'b1;
                free_idx = rlt_pkg::SLOT_IW'(i);
            end
            if (!zero[i]) begin
                blockable = 1'b0;
                if (!match[i]) begin
                    unique_req = 1'b0;
                end
            end
        end
    end

    always_comb begin
        add_row = row;
        add_st  = rlt_pkg::STAT_DONE;
        if (own_hit) begin
            if (row.count[own_idx] == rlt_pkg::COUNT_MAX) begin
                add_st = rlt_pkg::STAT_OVERFLOW;
            end else begin
                add_row.count[own_idx] = row.count[own_idx] + 1'b1;
            end
        end else if (free_hit) begin
            add_row.owner[free_idx] = in_reg.requester;
            add_row.count[free_idx] = rlt_pkg::COUNT_BITS'(1);
        end else begin
            add_st = rlt_pkg::STAT_NO_SLOT;
        end
    end

    always_comb begin
        rem_row  = row;
        rem_st   = rlt_pkg::STAT_DONE;
        last_ref = 1'b0;
        if (!own_hit || zero[own_idx]) begin
            rem_st = rlt_pkg::STAT_NOT_FOUND;
        end else begin
            rem_row.count[own_idx] = row.count[own_idx] - 1'b1;
            last_ref = (row.count[own_idx] == rlt_pkg::COUNT_BITS'(1));
            for (int i = 0; i < rlt_pkg::SLOTS; i++) begin
                if (rlt_pkg::SLOT_IW'(i) != own_idx && !zero[i]) begin
                    last_ref = 1'b0;
                end
            end
        end
    end

    always_comb begin
        row_next = row;
        status   = rlt_pkg::STAT_DONE;
        granted  = 1'b0;
        if (in_range) begin
            case (in_reg.action)
                rlt_pkg::ACT_PUSH: begin
                    if (row.blocked) begin
                        status = rlt_pkg::STAT_RETRY;
                    end else begin
                        status = add_st;
                        if (add_st == rlt_pkg::STAT_DONE) row_next = add_row;
                    end
                end
                rlt_pkg::ACT_POP: begin
                    if (row.blocked) begin
                        status = rlt_pkg::STAT_RETRY;
                    end else begin
                        status = rem_st;
                        if (rem_st == rlt_pkg::STAT_DONE) row_next = rem_row;
                    end
                end
                rlt_pkg::ACT_TRY_BLOCK: begin
                    if (row.blocked) begin
                        status = rlt_pkg::STAT_RETRY;
                    end else if (blockable) begin
                        status = add_st;
                        if (add_st == rlt_pkg::STAT_DONE) row_next = add_row;
                        row_next.blocked = 1'b1;
                        granted = 1'b1;
                    end
                end
                rlt_pkg::ACT_UNLOCK: begin
                    if (!row.blocked) begin
                        status = rlt_pkg::STAT_NOT_BLOCKED;
                    end else begin
                        status = rem_st;
                        if (rem_st == rlt_pkg::STAT_DONE) begin
                            row_next = rem_row;
                            row_next.blocked = 1'b0;
                        end
                    end
                end
                rlt_pkg::ACT_POP_AND_BLOCK: begin
                    if (row.blocked) begin
                        status = rlt_pkg::STAT_RETRY;
                    end else begin
                        status = rem_st;
                        if (rem_st == rlt_pkg::STAT_DONE) begin
                            if (last_ref) begin
                                row_next.blocked = 1'b1;
                                granted = 1'b1;
                            end else begin
                                row_next = rem_row;
                            end
                        end
                    end
                end
                rlt_pkg::ACT_HARD_BLOCK: begin
                    if (row.blocked || !unique_req) begin
                        status = rlt_pkg::STAT_RETRY;
                    end else begin
                        row_next.blocked = 1'b1;
                        granted = blockable;
                    end
                end
                rlt_pkg::ACT_HARD_UNLOCK: begin
                    if (!unique_req) begin
                        status = rlt_pkg::STAT_NOT_UNIQUE;
                    end else if (!row.blocked) begin
                        status = rlt_pkg::STAT_NOT_BLOCKED;
                    end else begin
                        row_next.blocked = 1'b0;
                    end
                end
                default: begin
                    status = rlt_pkg::STAT_DONE;
                end
            endcase
        end
    end

    // grant only from the blocking actions, and only with the route left blocked
    a_grant_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && granted) |-> row_next.blocked)
        else $error("grant without blocking the route");

    // a retry or error leaves the row unchanged
    a_error_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && status != rlt_pkg::STAT_DONE && !granted) |-> (row_next == row))
        else $error("failed action modified the route row");

    // a written row reads back valid on the next capture of that route
    a_write_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        write_en |=> row_valid_reg[$past(in_reg.route)])
        else $error("written row not marked valid");

endmodule

// ===== rtl/route_lock_table.sv =====
// ----------------------------------------------------------------------------
// route_lock_table: per-route lock table with reentrant requester slots
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one lock transaction (action, route,
//   requester). m_valid/m_ready/m_data return one result (granted, status)
//   for every transaction, in order.
//   Each transaction takes a registered read of its route row (rd_row_reg,
//   with the request in in_reg) followed by its read-modify-write in the
//   next cycle, which registers the result in out_reg.
//   The result stays in an output register; s_ready rises in the cycle in
//   which the pending result is taken, so the next transaction is accepted
//   while the current result leaves. While the receiver stalls, the result
//   holds and no new transaction is accepted.
//   Reset (aresetn low, synchronous) clears the controller and the per-route
//   valid bits; a route row never written reads as unblocked with all slots
//   empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module route_lock_table (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rlt_pkg::req_t    s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rlt_pkg::result_t m_data
);

    rlt_pkg::cmd_t cmd;

    rlt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rlt_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
